/* hw/rtl/rotation_matrix_to_quaternion_macros.svh */
// assertion macros for the rotation matrix to quaternion top level
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// property checked on every clock edge outside reset
`define RMQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on the edge after reset is seen low
`define RMQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

/* hw/rtl/rmq_pkg.sv */
// package with widths, types and helpers for the matrix to quaternion pipeline
`default_nettype none
package rmq_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned D_W        = SAMPLE_W + 2;
  localparam int unsigned ARG_W      = SAMPLE_W + 1;
  localparam int unsigned RAD_W      = 32;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SQ_REM_W   = ROOT_W + 3;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = ROOT_W + 1;
  localparam int unsigned QUO_W      = 24;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned LATENCY    = 4 + SQRT_STEPS + DIV_STEPS;
  localparam int unsigned LANES      = 3;

  localparam logic signed [D_W:0]        ONE   = (D_W+1)'(1) <<< FRAC_BITS;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // which output takes the half root
  typedef enum logic [1:0] {
    HSEL_X,
    HSEL_Y,
    HSEL_Z,
    HSEL_W
  } hsel_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] m11;
    logic signed [SAMPLE_W-1:0] m12;
    logic signed [SAMPLE_W-1:0] m13;
    logic signed [SAMPLE_W-1:0] m21;
    logic signed [SAMPLE_W-1:0] m22;
    logic signed [SAMPLE_W-1:0] m23;
    logic signed [SAMPLE_W-1:0] m31;
    logic signed [SAMPLE_W-1:0] m32;
    logic signed [SAMPLE_W-1:0] m33;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] qx;
    logic signed [SAMPLE_W-1:0] qy;
    logic signed [SAMPLE_W-1:0] qz;
    logic signed [SAMPLE_W-1:0] qw;
    logic                       invalid;
  } res_t;

  // routing and lane numerators that travel beside the square root
  typedef struct packed {
    hsel_e                   hsel;
    logic                    invalid;
    logic [LANES-1:0][D_W-1:0] lane;
  } side_t;

  // routing and half root that travel beside the dividers
  typedef struct packed {
    hsel_e             hsel;
    logic              invalid;
    logic [ROOT_W-1:0] half;
  } ctl_t;

  // sign extension of a matrix entry to the difference width
  function automatic logic signed [D_W-1:0] ext(input logic signed [SAMPLE_W-1:0] m);
    ext = {{(D_W-SAMPLE_W){m[SAMPLE_W-1]}}, m};
  endfunction

  // apply sign to a quotient magnitude and clamp to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat(input logic neg,
                                                    input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] negq;
    lim  = QUO_W'(S_MAX);
    negq = -q;
    if (neg) begin
      sat = (q > lim) ? S_MIN : negq[SAMPLE_W-1:0];
    end else begin
      sat = (q > lim) ? S_MAX : q[SAMPLE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rmq_front.sv */
// front end: trace, axis choice, square root argument and lane numerators
`default_nettype none
module rmq_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  rmq_pkg::req_t                req_i,
  output logic                         valid_o,
  output rmq_pkg::side_t               side_o,
  output logic [rmq_pkg::ARG_W-1:0]    arg_o
);
  import rmq_pkg::*;

  logic                 a_vld_q;
  req_t                 a_req_q;
  logic signed [D_W-1:0] a_trace_q;
  logic signed [D_W-1:0] trace_d;

  logic                  b_vld_q;
  side_t                 b_side_q, b_side_d;
  logic [ARG_W-1:0]      b_arg_q, b_arg_d;

  logic signed [D_W-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  logic signed [D_W:0]   arg;
  logic                  tpos;
  hsel_e                 hsel;

  // trace of the incoming request
  assign trace_d = ext(req_i.m11) + ext(req_i.m22) + ext(req_i.m33);

  // stage a: capture request and trace
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_req_q   <= req_i;
    a_trace_q <= trace_d;
  end

  assign e11 = ext(a_req_q.m11);
  assign e12 = ext(a_req_q.m12);
  assign e13 = ext(a_req_q.m13);
  assign e21 = ext(a_req_q.m21);
  assign e22 = ext(a_req_q.m22);
  assign e23 = ext(a_req_q.m23);
  assign e31 = ext(a_req_q.m31);
  assign e32 = ext(a_req_q.m32);
  assign e33 = ext(a_req_q.m33);

  assign tpos = (a_trace_q > 0);

  // pick the leading axis, strict compares in axis order
  always_comb begin
    if (tpos) begin
      hsel = HSEL_W;
    end else if (e22 > e11) begin
      hsel = (e33 > e22) ? HSEL_Z : HSEL_Y;
    end else begin
      hsel = (e33 > e11) ? HSEL_Z : HSEL_X;
    end
  end

  // square root argument and lane numerators with signs folded in
  always_comb begin
    arg = '0;
    b_side_d.lane = '0;
    unique case (hsel)
      HSEL_W: begin
        arg = (D_W+1)'(a_trace_q) + ONE;
        b_side_d.lane[0] = e23 - e32;
        b_side_d.lane[1] = e31 - e13;
        b_side_d.lane[2] = e12 - e21;
      end
      HSEL_X: begin
        arg = (D_W+1)'(e11) - (D_W+1)'(e22) - (D_W+1)'(e33) + ONE;
        b_side_d.lane[0] = -(e21 + e12);
        b_side_d.lane[1] = -(e31 + e13);
        b_side_d.lane[2] = e32 - e23;
      end
      HSEL_Y: begin
        arg = (D_W+1)'(e22) - (D_W+1)'(e33) - (D_W+1)'(e11) + ONE;
        b_side_d.lane[0] = -(e12 + e21);
        b_side_d.lane[1] = -(e32 + e23);
        b_side_d.lane[2] = e13 - e31;
      end
      HSEL_Z: begin
        arg = (D_W+1)'(e33) - (D_W+1)'(e11) - (D_W+1)'(e22) + ONE;
        b_side_d.lane[0] = -(e13 + e31);
        b_side_d.lane[1] = -(e23 + e32);
        b_side_d.lane[2] = e21 - e12;
      end
      default: begin
        arg = '0;
      end
    endcase
    b_side_d.hsel    = hsel;
    b_side_d.invalid = (arg <= 0);
    b_arg_d          = b_side_d.invalid ? '0 : arg[ARG_W-1:0];
  end

  // stage b: registered argument and sideband
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q <= b_side_d;
    b_arg_q  <= b_arg_d;
  end

  assign valid_o = b_vld_q;
  assign side_o  = b_side_q;
  assign arg_o   = b_arg_q;

endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module rmq_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [rmq_pkg::ARG_W-1:0]     arg_i,
  input  rmq_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [rmq_pkg::ROOT_W-1:0]    root_o,
  output rmq_pkg::side_t                side_o
);
  import rmq_pkg::*;

  logic                vld_q  [SQRT_STEPS+1];
  logic [RAD_W-1:0]    rad_q  [SQRT_STEPS+1];
  logic [SQ_REM_W-1:0] rem_q  [SQRT_STEPS+1];
  logic [ROOT_W-1:0]   root_q [SQRT_STEPS+1];
  side_t               side_q [SQRT_STEPS+1];

  // stage zero is the incoming request, argument scaled by one
  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = RAD_W'({arg_i, {FRAC_BITS{1'b0}}});
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                take;

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_q[g][SQ_REM_W-3:0], rad_q[g][RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_q[g], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g+1]  <= rad_q[g] << 2;
      rem_q[g+1]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[g+1] <= {root_q[g][ROOT_W-2:0], take};
      side_q[g+1] <= side_q[g];
    end
  end

  assign valid_o = vld_q[SQRT_STEPS];
  assign root_o  = root_q[SQRT_STEPS];
  assign side_o  = side_q[SQRT_STEPS];

endmodule
`default_nettype wire

/* hw/rtl/rmq_div.sv */
// pipelined restoring divider lane, one quotient bit per stage
`default_nettype none
module rmq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rmq_pkg::NUM_W-1:0]   num_i,
  input  logic [rmq_pkg::DEN_W-1:0]   den_i,
  input  logic                        neg_i,
  output logic                        valid_o,
  output logic [rmq_pkg::QUO_W-1:0]   quot_o,
  output logic                        neg_o
);
  import rmq_pkg::*;

  localparam int unsigned X_W = DEN_W + QUO_W;

  logic             vld_q [DIV_STEPS+1];
  logic [X_W-1:0]   x_q   [DIV_STEPS+1];
  logic [DEN_W-1:0] den_q [DIV_STEPS+1];
  logic             neg_q [DIV_STEPS+1];

  // quotient fits the low bits, so the top numerator bits start the remainder
  assign vld_q[0] = valid_i;
  assign x_q[0]   = X_W'(num_i);
  assign den_q[0] = den_i;
  assign neg_q[0] = neg_i;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             take;

    // shift in the next numerator bit and subtract where it fits
    assign rem_sh = x_q[g][X_W-1 -: DEN_W+1];
    assign take   = (rem_sh >= {1'b0, den_q[g]});
    assign diff   = take ? (rem_sh - {1'b0, den_q[g]}) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[g+1]   <= {diff[DEN_W-1:0], x_q[g][QUO_W-2:0], take};
      den_q[g+1] <= den_q[g];
      neg_q[g+1] <= neg_q[g];
    end
  end

  assign valid_o = vld_q[DIV_STEPS];
  assign quot_o  = x_q[DIV_STEPS][QUO_W-1:0];
  assign neg_o   = neg_q[DIV_STEPS];

endmodule
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to quaternion converter, fully pipelined. One request of
// nine Q2.14 entries may be given with start in every clock cycle; busy is
// always low. Each request yields one quaternion on res_o with done_o high
// for a single cycle, in request order. A request passes two front stages,
// the square root (16 stages, one root bit each), one scaling stage, then
// the three parallel dividers (24 stages, one quotient bit each) and the
// output register. Results cannot be held back by the receiver and must
// be taken as shown.
`default_nettype none
module rotation_matrix_to_quaternion (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  rmq_pkg::req_t  req_i,
  output logic           busy,
  output logic           done_o,
  output rmq_pkg::res_t  res_o
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_macros.svh"

  logic              fr_vld;
  side_t             fr_side;
  logic [ARG_W-1:0]  fr_arg;

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  logic                         pr_vld_q;
  ctl_t                         pr_ctl_q, pr_ctl_d;
  logic [LANES-1:0][NUM_W-1:0]  pr_num_q, pr_num_d;
  logic [LANES-1:0]             pr_neg_q, pr_neg_d;
  logic [DEN_W-1:0]             pr_den_q;
  logic [ROOT_W:0]              root_inc;

  logic [LANES-1:0]             dv_vld;
  logic [LANES-1:0][QUO_W-1:0]  dv_quot;
  logic [LANES-1:0]             dv_neg;
  ctl_t                         ctl_q [DIV_STEPS+1];

  logic                         done_q;
  res_t                         res_q, res_d;
  logic signed [SAMPLE_W-1:0]   s0, s1, s2, hp, hn;
  logic                         res_zero;

  // the pipeline never stalls
  assign busy = 1'b0;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .req_i   (req_i),
    .valid_o (fr_vld),
    .side_o  (fr_side),
    .arg_o   (fr_arg)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld),
    .arg_i   (fr_arg),
    .side_i  (fr_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // scaling: numerators with rounding bias, divisor and half root
  assign root_inc = {1'b0, sq_root} + (ROOT_W+1)'(1);

  always_comb begin
    logic signed [D_W-1:0] v;
    logic [D_W-1:0]        mag;
    for (int l = 0; l < LANES; l++) begin
      v           = $signed(sq_side.lane[l]);
      mag         = v[D_W-1] ? D_W'(-v) : D_W'(v);
      pr_num_d[l] = NUM_W'({mag[D_W-2:0], {FRAC_BITS{1'b0}}}) + NUM_W'(sq_root);
      pr_neg_d[l] = v[D_W-1];
    end
    pr_ctl_d.hsel    = sq_side.hsel;
    pr_ctl_d.invalid = sq_side.invalid;
    pr_ctl_d.half    = root_inc[ROOT_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else begin
      pr_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_ctl_q <= pr_ctl_d;
    pr_num_q <= pr_num_d;
    pr_neg_q <= pr_neg_d;
    pr_den_q <= {sq_root, 1'b0};
  end

  // three divider lanes share the divisor
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rmq_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pr_vld_q),
      .num_i   (pr_num_q[l]),
      .den_i   (pr_den_q),
      .neg_i   (pr_neg_q[l]),
      .valid_o (dv_vld[l]),
      .quot_o  (dv_quot[l]),
      .neg_o   (dv_neg[l])
    );
  end

  // routing and half root delayed to match the dividers
  assign ctl_q[0] = pr_ctl_q;
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_ctl
    always_ff @(posedge clk_i) begin
      ctl_q[g+1] <= ctl_q[g];
    end
  end

  // clamp lanes and place them around the half root
  assign s0 = sat(dv_neg[0], dv_quot[0]);
  assign s1 = sat(dv_neg[1], dv_quot[1]);
  assign s2 = sat(dv_neg[2], dv_quot[2]);
  assign hp = $signed(ctl_q[DIV_STEPS].half);
  assign hn = -hp;

  always_comb begin
    res_d = '0;
    unique case (ctl_q[DIV_STEPS].hsel)
      HSEL_W: begin
        res_d.qx = s0; res_d.qy = s1; res_d.qz = s2; res_d.qw = hp;
      end
      HSEL_X: begin
        res_d.qx = hn; res_d.qy = s0; res_d.qz = s1; res_d.qw = s2;
      end
      HSEL_Y: begin
        res_d.qx = s0; res_d.qy = hn; res_d.qz = s1; res_d.qw = s2;
      end
      HSEL_Z: begin
        res_d.qx = s0; res_d.qy = s1; res_d.qz = hn; res_d.qw = s2;
      end
      default: begin
        res_d = '0;
      end
    endcase
    if (ctl_q[DIV_STEPS].invalid) begin
      res_d = '0;
      res_d.invalid = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // all four components zero
  assign res_zero = (res_o[4*SAMPLE_W:1] == '0);

  `RMQ_ASSERT(a_lat_fwd, clk_i, rst_ni, start |-> ##LATENCY done_o, "request without result")
  `RMQ_ASSERT(a_lat_bwd, clk_i, rst_ni, done_o |-> $past(start, LATENCY), "result without request")
  `RMQ_ASSERT(a_inv_zero, clk_i, rst_ni, done_o && res_o.invalid |-> res_zero, "invalid not zero")
  `RMQ_ASSERT_RST(a_rst_done, clk_i, rst_ni, !done_o, "result strobe after reset")

endmodule
`default_nettype wire
